### hw/rtl/rational_arith_reduce_macros.svh
// Assertion macros shared by the rational arithmetic block.
`ifndef RATIONAL_ARITH_REDUCE_MACROS_SVH
`define RATIONAL_ARITH_REDUCE_MACROS_SVH
`define RAR_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);
`define RAR_ASSERT_NEXT(lbl, clk, rstn, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (pre) |=> (post)) else $error(msg);
`endif

### hw/rtl/rar_pkg.sv
// Package with types, codes and widths of the rational arithmetic block.
package rar_pkg;
  localparam int unsigned OpBits  = 32;
  localparam int unsigned DenBits = OpBits - 1;
  localparam int unsigned ResBits = 2 * OpBits;
  localparam int unsigned CntBits = $clog2(ResBits + 1);

  typedef enum logic [1:0] {
    ActAdd = 2'd0,
    ActSub = 2'd1,
    ActMul = 2'd2,
    ActDiv = 2'd3
  } action_e;

  typedef struct packed {
    logic [1:0]                action;
    logic signed [OpBits-1:0]  a_num;
    logic [DenBits-1:0]        a_den;
    logic signed [OpBits-1:0]  b_num;
    logic [DenBits-1:0]        b_den;
  } req_t;

  typedef struct packed {
    logic signed [ResBits-1:0] res_num;
    logic [ResBits-2:0]        res_den;
    logic                      status;
  } rsp_t;

  // Job handed from the front to the back: magnitudes and flags.
  typedef struct packed {
    logic [ResBits-1:0] mag_n;
    logic [ResBits-1:0] mag_d;
    logic               neg;
    logic               zero_d;
    logic               zero_n;
  } job_t;

  typedef enum logic [2:0] {
    FeIdle, FeMul, FeSum, FeDone
  } fe_state_e;

  typedef enum logic [2:0] {
    BeIdle, BeGcd, BeDivN, BeDivD, BeOut
  } be_state_e;
endpackage

### hw/rtl/rar_front.sv
// Front end: cross-multiplies the operands and forms sign and magnitudes.
module rar_front import rar_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  output logic full_o,
  input  req_t req_i,
  output logic job_valid_o,
  input  logic job_ready_i,
  output job_t job_o
);
  fe_state_e state_q, state_d;
  req_t req_q;
  logic signed [ResBits-1:0] p0_q, p1_q, p0_d, p1_d, n_q, d_q, n_d, d_d;
  logic signed [ResBits-1:0] p2_q, p2_d;
  logic signed [OpBits:0] m0a, m0b, m1a, m1b, m2b;
  logic signed [ResBits-1:0] nfix, dfix;

  always_comb begin
    m0a = {req_q.a_num[OpBits-1], req_q.a_num};
    m0b = {2'b00, req_q.b_den};
    m1a = {2'b00, req_q.a_den};
    m1b = {req_q.b_num[OpBits-1], req_q.b_num};
    m2b = {2'b00, req_q.b_den};
    unique case (action_e'(req_q.action))
      ActMul: begin
        m0b = {req_q.b_num[OpBits-1], req_q.b_num};
        m1b = {2'b00, req_q.b_den};
      end
      default: ;
    endcase
    p0_d = m0a * m0b;
    p1_d = m1a * m1b;
    p2_d = m1a * m2b;
  end

  always_comb begin
    n_d = n_q;
    d_d = d_q;
    unique case (action_e'(req_q.action))
      ActAdd: begin n_d = p0_q + p1_q; d_d = p2_q; end
      ActSub: begin n_d = p0_q - p1_q; d_d = p2_q; end
      ActMul: begin n_d = p0_q; d_d = p1_q; end
      default: begin n_d = p0_q; d_d = p1_q; end
    endcase
  end

  always_comb begin
    nfix = d_q[ResBits-1] ? -n_q : n_q;
    dfix = d_q[ResBits-1] ? -d_q : d_q;
    job_o.neg    = nfix[ResBits-1];
    job_o.mag_n  = nfix[ResBits-1] ? -nfix : nfix;
    job_o.mag_d  = dfix;
    job_o.zero_d = (d_q == '0);
    job_o.zero_n = (n_q == '0);
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      FeIdle: if (push_i) state_d = FeMul;
      FeMul:  state_d = FeSum;
      FeSum:  state_d = FeDone;
      FeDone: if (job_ready_i) state_d = FeIdle;
      default: state_d = FeIdle;
    endcase
  end

  assign full_o      = (state_q != FeIdle);
  assign job_valid_o = (state_q == FeDone);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= FeIdle;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == FeIdle && push_i) req_q <= req_i;
    if (state_q == FeMul) begin
      p0_q <= p0_d;
      p1_q <= p1_d;
      p2_q <= p2_d;
    end
    if (state_q == FeSum) begin
      n_q <= n_d;
      d_q <= d_d;
    end
  end
endmodule

### hw/rtl/rar_fifo.sv
// Two-entry queue between the front and the back end.
module rar_fifo import rar_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_ready_o,
  input  job_t in_i,
  output logic out_valid_o,
  input  logic out_ready_i,
  output job_t out_o
);
  job_t mem_q [2];
  logic wp_q, rp_q;
  logic [1:0] cnt_q;
  logic wr, rd;

  assign in_ready_o  = (cnt_q != 2'd2);
  assign out_valid_o = (cnt_q != 2'd0);
  assign out_o       = mem_q[rp_q];
  assign wr = in_valid_i && in_ready_o;
  assign rd = out_valid_o && out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= 1'b0;
      rp_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (wr) wp_q <= ~wp_q;
      if (rd) rp_q <= ~rp_q;
      cnt_q <= cnt_q + 2'(wr) - 2'(rd);
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr) mem_q[wp_q] <= in_i;
  end
endmodule

### hw/rtl/rar_back.sv
// Back end: binary-search-free Euclid gcd and two restoring divisions.
module rar_back import rar_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic job_valid_i,
  output logic job_ready_o,
  input  job_t job_i,
  output logic empty_o,
  input  logic pop_i,
  output rsp_t rsp_o
);
  be_state_e state_q, state_d;
  job_t job_q;
  logic [ResBits-1:0] x_q, y_q, rem_q, quo_q, dvs_q, qn_q;
  logic [CntBits-1:0] cnt_q;
  logic [ResBits:0] trial;
  logic [ResBits-1:0] rem_nx, quo_nx;
  logic div_last;
  rsp_t rsp_q;

  // One restoring division step per cycle; used for x mod y, n / g and d / g.
  assign trial    = {rem_q, quo_q[ResBits-1]} - {1'b0, dvs_q};
  assign rem_nx   = trial[ResBits] ? {rem_q[ResBits-2:0], quo_q[ResBits-1]} : trial[ResBits-1:0];
  assign quo_nx   = {quo_q[ResBits-2:0], ~trial[ResBits]};
  assign div_last = (cnt_q == CntBits'(1));

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      BeIdle: if (job_valid_i) state_d = BeGcd;
      BeGcd:  if (y_q == '0 && cnt_q == '0) state_d = BeDivN;
      BeDivN: if (div_last) state_d = BeDivD;
      BeDivD: if (div_last) state_d = BeOut;
      BeOut:  if (pop_i) state_d = BeIdle;
      default: state_d = BeIdle;
    endcase
    if (state_q == BeIdle && job_valid_i && (job_i.zero_d || job_i.zero_n)) state_d = BeOut;
  end

  assign job_ready_o = (state_q == BeIdle);
  assign empty_o     = (state_q != BeOut);
  assign rsp_o       = rsp_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= BeIdle;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      unique case (state_q)
        BeIdle: cnt_q <= '0;
        BeGcd: begin
          if (cnt_q != '0) cnt_q <= cnt_q - CntBits'(1);
          else if (y_q != '0) cnt_q <= CntBits'(ResBits);
          else cnt_q <= CntBits'(ResBits);
        end
        BeDivN, BeDivD: cnt_q <= div_last ? CntBits'(ResBits) : cnt_q - CntBits'(1);
        default: cnt_q <= '0;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    unique case (state_q)
      BeIdle: begin
        job_q <= job_i;
        x_q   <= job_i.mag_n;
        y_q   <= job_i.mag_d;
        rsp_q.res_num <= '0;
        rsp_q.res_den <= (job_i.zero_n && !job_i.zero_d) ? (ResBits-1)'(1) : '0;
        rsp_q.status  <= job_i.zero_d;
      end
      BeGcd: begin
        if (cnt_q == '0) begin
          rem_q <= '0;
          if (y_q != '0) begin
            quo_q <= x_q;
            dvs_q <= y_q;
          end else begin
            quo_q <= job_q.mag_n;
            dvs_q <= x_q;
          end
        end else begin
          rem_q <= rem_nx;
          quo_q <= quo_nx;
          if (div_last) begin
            x_q <= y_q;
            y_q <= rem_nx;
          end
        end
      end
      BeDivN, BeDivD: begin
        if (!div_last) begin
          rem_q <= rem_nx;
          quo_q <= quo_nx;
        end else begin
          rem_q <= '0;
          if (state_q == BeDivN) begin
            qn_q  <= quo_nx;
            quo_q <= job_q.mag_d;
          end else begin
            rsp_q.res_num <= job_q.neg ? -qn_q : qn_q;
            rsp_q.res_den <= quo_nx[ResBits-2:0];
            rsp_q.status  <= 1'b0;
          end
        end
      end
      default: ;
    endcase
  end
endmodule

### hw/rtl/rational_arith_reduce.sv
// Top level of the rational arithmetic block with gcd reduction.
// The front end takes one request, forms the cross products and then the sign, and
// hands the job to a two-entry queue, so up to four requests can be in flight.
// The back end runs Euclid with a bit-serial 64-step divider for each remainder,
// then two 64-step divisions for the reduced numerator and denominator.
// A zero numerator gives 0/1 and a zero denominator gives status 1 in the cycle
// after the job reaches the back end.
`include "rational_arith_reduce_macros.svh"
module rational_arith_reduce import rar_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push,
  output logic full,
  input  req_t req_i,
  output logic empty,
  input  logic pop,
  output rsp_t rsp_o
);
  logic j_valid, j_ready, q_valid, q_ready;
  job_t j_data, q_data;

  rar_front u_front (
    .clk_i, .rst_ni, .push_i(push), .full_o(full), .req_i,
    .job_valid_o(j_valid), .job_ready_i(j_ready), .job_o(j_data)
  );

  rar_fifo u_fifo (
    .clk_i, .rst_ni, .in_valid_i(j_valid), .in_ready_o(j_ready), .in_i(j_data),
    .out_valid_o(q_valid), .out_ready_i(q_ready), .out_o(q_data)
  );

  rar_back u_back (
    .clk_i, .rst_ni, .job_valid_i(q_valid), .job_ready_o(q_ready), .job_i(q_data),
    .empty_o(empty), .pop_i(pop), .rsp_o
  );

  `RAR_ASSERT(a_ok_den, clk_i, rst_ni, empty || rsp_o.status || rsp_o.res_den != '0, "zero den")
  `RAR_ASSERT_NEXT(a_hold, clk_i, rst_ni, !empty && !pop, !empty && $stable(rsp_o), "rsp moved")
endmodule

### test/rar_checker.sv
// Checker for the rational arithmetic block: predicts each reduced fraction and compares.
`timescale 1ns / 100ps
module rar_checker import rar_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  logic full_i,
  input  req_t req_i,
  input  logic empty_i,
  input  logic pop_i,
  input  rsp_t rsp_i,
  output int   fails_o,
  output int   pending_o
);

  rsp_t fraction_q[$];

  function automatic logic [63:0] gcd64(logic [63:0] x, logic [63:0] y);
    logic [63:0] r;
    while (y != 0) begin
      r = x % y;
      x = y;
      y = r;
    end
    return x;
  endfunction

  function automatic rsp_t reduce_fraction(req_t r);
    rsp_t o;
    logic signed [63:0] an, ad, bn, bd, n, d;
    logic [63:0] un, ud, g;
    an = 64'(r.a_num);
    bn = 64'(r.b_num);
    ad = {33'd0, r.a_den};
    bd = {33'd0, r.b_den};
    case (action_e'(r.action))
      ActAdd: begin
        n = an * bd + ad * bn;
        d = ad * bd;
      end
      ActSub: begin
        n = an * bd - ad * bn;
        d = ad * bd;
      end
      ActMul: begin
        n = an * bn;
        d = ad * bd;
      end
      default: begin
        n = an * bd;
        d = ad * bn;
      end
    endcase
    o = '0;
    if (d == 0) begin
      o.status = 1'b1;
      return o;
    end
    if (d < 0) begin
      d = -d;
      n = -n;
    end
    if (n == 0) begin
      o.res_den = 63'd1;
      return o;
    end
    un = (n < 0) ? -n : n;
    ud = d;
    g = gcd64(un, ud);
    un = un / g;
    ud = ud / g;
    o.res_num = (n < 0) ? -un : un;
    o.res_den = ud[62:0];
    return o;
  endfunction

  task automatic report(string what);
    $display("mismatch: %s", what);
    fails_o++;
  endtask

  initial fails_o = 0;
  assign pending_o = fraction_q.size();

  always @(posedge clk_i) begin
    rsp_t e;
    if (rst_ni) begin
      if (push_i && !full_i) fraction_q.push_front(reduce_fraction(req_i));
      if (pop_i && !empty_i) begin
        if (fraction_q.size() == 0) begin
          report("response with no request waiting");
        end else begin
          e = fraction_q.pop_back();
          if (rsp_i.res_num !== e.res_num)
            report($sformatf("res_num %0d, expected %0d", rsp_i.res_num, e.res_num));
          if (rsp_i.res_den !== e.res_den)
            report($sformatf("res_den %0d, expected %0d", rsp_i.res_den, e.res_den));
          if (rsp_i.status !== e.status)
            report($sformatf("status %0b, expected %0b", rsp_i.status, e.status));
        end
      end
    end
  end

endmodule

### test/tb_top.sv
// Testbench top for the rational arithmetic block: stimulus, stalls and verdict.
`timescale 1ns / 100ps
module tb_top;
  import rar_pkg::*;

  localparam int NumRandom = 1400;
  localparam int CycleLimit = 40000000;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic push = 1'b0;
  logic full;
  req_t req = '0;
  logic empty;
  logic pop = 1'b0;
  rsp_t rsp;
  int   fails;
  int   pending;
  int   cycles = 0;
  bit   hold_off = 1'b0;

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  rational_arith_reduce DUT (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .push  (push),
    .full  (full),
    .req_i (req),
    .empty (empty),
    .pop   (pop),
    .rsp_o (rsp)
  );

  rar_checker u_checker (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .push_i   (push),
    .full_i   (full),
    .req_i    (req),
    .empty_i  (empty),
    .pop_i    (pop),
    .rsp_i    (rsp),
    .fails_o  (fails),
    .pending_o(pending)
  );

  function automatic logic [31:0] rand_num();
    case ($urandom_range(0, 5))
      0: return 32'h8000_0000;
      1: return 32'h7fff_ffff;
      2: return 32'(int'($urandom_range(0, 40)) - 20);
      3: return {$urandom_range(0, 1) ? 16'hffff : 16'h0, 16'($urandom)};
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [30:0] rand_den();
    case ($urandom_range(0, 5))
      0: return 31'h7fff_ffff;
      1: return 31'($urandom_range(0, 3));
      2: return 31'($urandom_range(1, 1000));
      default: return 31'($urandom);
    endcase
  endfunction

  task automatic send(logic [1:0] act, logic [31:0] an, logic [30:0] ad,
                      logic [31:0] bn, logic [30:0] bd);
    req <= '{action: act, a_num: an, a_den: ad, b_num: bn, b_den: bd};
    push <= 1'b1;
    @(posedge clk_i);
    while (full) @(posedge clk_i);
  endtask

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("FAIL");
      $finish;
    end
  end

  initial begin
    wait (rst_ni);
    repeat (200) @(posedge clk_i);
    hold_off <= 1'b1;
    repeat (30000) @(posedge clk_i);
    hold_off <= 1'b0;
  end

  initial begin
    @(posedge clk_i);
    forever begin
      if (!hold_off && $urandom_range(0, 199) == 0) begin
        pop <= 1'b0;
        repeat ($urandom_range(5, 40)) @(posedge clk_i);
      end else begin
        if (hold_off) pop <= 1'b0;
        else pop <= ($urandom_range(0, 3) != 0) || ($urandom_range(0, 99) < 5 ? 1'b0 : 1'b1);
        @(posedge clk_i);
      end
    end
  end

  initial begin
    int burst;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    send(ActAdd, 32'h8000_0000, 31'h7fff_ffff, 32'h8000_0000, 31'h7fff_ffff);
    send(ActSub, 32'h8000_0000, 31'h7fff_ffff, 32'h7fff_ffff, 31'h7fff_ffff);
    send(ActMul, 32'h8000_0000, 31'd1, 32'h8000_0000, 31'd1);
    send(ActDiv, 32'h8000_0000, 31'h7fff_ffff, 32'h8000_0000, 31'd1);
    send(ActDiv, 32'd3, 31'd4, 32'hffff_fffe, 31'd5);
    send(ActDiv, 32'd3, 31'd4, 32'd0, 31'd5);
    send(ActDiv, 32'd0, 31'd4, 32'd0, 31'd5);
    send(ActAdd, 32'd1, 31'd0, 32'd1, 31'd2);
    send(ActMul, 32'd0, 31'd0, 32'd0, 31'd0);
    send(ActSub, 32'd5, 31'd7, 32'd5, 31'd7);
    send(ActAdd, 32'd1, 31'd2, 32'hffff_ffff, 31'd2);
    send(ActMul, 32'd0, 31'd9, 32'd7, 31'd3);
    send(ActAdd, 32'd6, 31'd4, 32'd2, 31'd8);
    send(ActSub, 32'hffff_ffff, 31'd3, 32'd1, 31'd3);
    send(ActMul, 32'h7fff_ffff, 31'h7fff_ffff, 32'h7fff_ffff, 31'h7fff_ffff);
    send(ActDiv, 32'hffff_ffff, 31'd1, 32'hffff_ffff, 31'd1);
    send(ActAdd, 32'hffff_ffff, 31'h5555_5555, 32'h5555_5555, 31'h2aaa_aaaa);
    for (int i = 0; i < 12; i++) send(2'($urandom), rand_num(), rand_den(), rand_num(), rand_den());
    push <= 1'b0;
    repeat (3000) @(posedge clk_i);
    for (int i = 0; i < NumRandom; ) begin
      burst = $urandom_range(1, 20);
      for (int k = 0; k < burst && i < NumRandom; k++, i++)
        send(2'($urandom), rand_num(), rand_den(), rand_num(), rand_den());
      if ($urandom_range(0, 2) != 0) begin
        push <= 1'b0;
        repeat ($urandom_range(1, 400)) @(posedge clk_i);
      end
    end
    push <= 1'b0;
    while (pending != 0) @(posedge clk_i);
    repeat (1000) @(posedge clk_i);
    if (fails == 0) $display("PASS");
    else $display("FAIL");
    $finish;
  end

endmodule
